@@ rtl/svcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svcd_pkg
// Shared types and constants of the serial velocity command deframer.
// ----------------------------------------------------------------------------
package svcd_pkg;

   localparam int unsigned POS_W   = 4;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned SPEED_W = 16;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned CSR_W   = 1;

   // frame layout
   localparam logic [POS_W-1:0] POS_HEADER      = 4'd0;
   localparam logic [POS_W-1:0] POS_FIRST_SPEED = 4'd3;
   localparam logic [POS_W-1:0] POS_LAST_SPEED  = 4'd8;
   localparam logic [POS_W-1:0] POS_CHECK       = 4'd9;
   localparam logic [POS_W-1:0] POS_TAIL        = 4'd10;
   localparam logic [POS_W-1:0] FRAME_LEN       = 4'd11;

   // frame status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_TAIL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_SUM  = 2'd2;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_HEADER = 1'd0;
   localparam logic [CSR_W-1:0] CSR_TAIL   = 1'd1;

   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd123;
   localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'd125;

   localparam int unsigned CMD_DEPTH_DEFAULT = 4;

   // one classified frame byte handed from front to back
   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [BYTE_W-1:0] data;
   } cmd_type;

endpackage

@@ rtl/serial_velocity_command_deframer.sv @@
`timescale 1ns / 1ps
// a frame result reaches the rsp_ ports via the command queue and the back's result register
// throughput: one word per cycle unless full; the front tags words, the queue feeds the back
// the back drains one word per cycle and stalls only on a tail word while the result is unread
// reset (synchronous, active high) empties both queues, returns to header hunt,
// and loads header 123 and tail 125
// ----------------------------------------------------------------------------
// serial_velocity_command_deframer
// Finds 11-byte velocity command frames in a serial byte stream and checks them.
// ----------------------------------------------------------------------------
module serial_velocity_command_deframer #(
   parameter int unsigned CMD_DEPTH = svcd_pkg::CMD_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // byte input, queue style
   input  logic                                push,
   output logic                                full,
   input  logic [svcd_pkg::BYTE_W-1:0]         req_rx_byte,
   input  logic                                req_startup_hold,
   // frame results, queue style
   output logic                                empty,
   input  logic                                pop,
   output logic [svcd_pkg::STAT_W-1:0]         rsp_frame_status,
   output logic signed [svcd_pkg::SPEED_W-1:0] rsp_target_x_mm_s,
   output logic signed [svcd_pkg::SPEED_W-1:0] rsp_target_y_mm_s,
   output logic signed [svcd_pkg::SPEED_W-1:0] rsp_target_z_mm_s,
   // register writes
   input  logic                                csr_we,
   input  logic [svcd_pkg::CSR_W-1:0]          csr_addr,
   input  logic [svcd_pkg::BYTE_W-1:0]         csr_wdata
);
   import svcd_pkg::*;

   // configuration registers
   logic [BYTE_W-1:0] header_ff, header_in;
   logic [BYTE_W-1:0] tail_ff, tail_in;

   // front to queue
   logic    accept;
   logic    cmd_push;
   cmd_type cmd_wr;

   // queue to back
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_rd;

   logic    rsp_valid;

   always_comb begin
      header_in = header_ff;
      tail_in   = tail_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_HEADER: header_in = csr_wdata;
            CSR_TAIL:   tail_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         tail_ff   <= TAIL_RESET;
      end else begin
         header_ff <= header_in;
         tail_ff   <= tail_in;
      end
   end

   // a word is taken whenever the command queue has room
   assign accept = push && !full;

   svcd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_rx_byte),
      .startup_hold (req_startup_hold),
      .header_byte  (header_ff),
      .cmd_push     (cmd_push),
      .cmd          (cmd_wr)
   );

   // dropped and non-header hunt words never enter the queue
   svcd_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd_wr),
      .full     (full),
      .pop      (cmd_pop),
      .valid    (cmd_valid),
      .pop_cmd  (cmd_rd)
   );

   // back end holds the finished result; a pop frees it in the same cycle
   svcd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd_rd),
      .cmd_pop       (cmd_pop),
      .tail_byte     (tail_ff),
      .rsp_valid     (rsp_valid),
      .rsp_take      (pop),
      .frame_status  (rsp_frame_status),
      .target_x_mm_s (rsp_target_x_mm_s),
      .target_y_mm_s (rsp_target_y_mm_s),
      .target_z_mm_s (rsp_target_z_mm_s)
   );

   assign empty = !rsp_valid;

endmodule

@@ rtl/svcd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svcd_front
// Tracks the frame position and tags each kept byte with it.
// ----------------------------------------------------------------------------
module svcd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [svcd_pkg::BYTE_W-1:0]   rx_byte,
   input  logic                          startup_hold,
   input  logic [svcd_pkg::BYTE_W-1:0]   header_byte,
   output logic                          cmd_push,
   output svcd_pkg::cmd_type             cmd
);
   import svcd_pkg::*;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             hunting;

   assign hunting = (pos_ff == POS_HEADER) || (pos_ff >= FRAME_LEN);

   always_comb begin
      pos_in   = pos_ff;
      cmd_push = 1'b0;
      cmd.pos  = pos_ff;
      cmd.data = rx_byte;
      if (accept && !startup_hold) begin
         if (hunting) begin
            cmd.pos = POS_HEADER;
            if (rx_byte == header_byte) begin
               cmd_push = 1'b1;
               pos_in   = POS_HEADER + 4'd1;
            end else begin
               pos_in = POS_HEADER;
            end
         end else begin
            cmd_push = 1'b1;
            pos_in   = (pos_ff == POS_TAIL) ? POS_HEADER : pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HEADER;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

@@ rtl/svcd_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svcd_cmd_fifo
// Short queue of tagged bytes between front and back.
// ----------------------------------------------------------------------------
module svcd_cmd_fifo #(
   parameter int unsigned DEPTH = svcd_pkg::CMD_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  svcd_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output svcd_pkg::cmd_type pop_cmd
);
   import svcd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/svcd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svcd_back
// Runs checksum and speed assembly on tagged bytes, holds the result word.
// ----------------------------------------------------------------------------
module svcd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   input  svcd_pkg::cmd_type                   cmd,
   output logic                                cmd_pop,
   input  logic [svcd_pkg::BYTE_W-1:0]         tail_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_take,
   output logic [svcd_pkg::STAT_W-1:0]         frame_status,
   output logic signed [svcd_pkg::SPEED_W-1:0] target_x_mm_s,
   output logic signed [svcd_pkg::SPEED_W-1:0] target_y_mm_s,
   output logic signed [svcd_pkg::SPEED_W-1:0] target_z_mm_s
);
   import svcd_pkg::*;

   logic [BYTE_W-1:0]  xor_ff, xor_in;
   logic               match_ff, match_in;
   logic [SPEED_W-1:0] spd_x_ff, spd_y_ff, spd_z_ff;
   logic [SPEED_W-1:0] spd_x_in, spd_y_in, spd_z_in;
   logic               out_valid_ff, out_valid_in;
   logic [STAT_W-1:0]  stat_ff, stat_in;
   logic [SPEED_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic [SPEED_W-1:0] out_x_in, out_y_in, out_z_in;
   logic               is_tail;
   logic               slot_free;

   assign is_tail   = (cmd.pos == POS_TAIL);
   assign slot_free = !out_valid_ff || rsp_take;
   // only the tail byte needs room in the result register
   assign cmd_pop   = cmd_valid && (!is_tail || slot_free);

   always_comb begin
      xor_in       = xor_ff;
      match_in     = match_ff;
      spd_x_in     = spd_x_ff;
      spd_y_in     = spd_y_ff;
      spd_z_in     = spd_z_ff;
      out_valid_in = out_valid_ff && !rsp_take;
      stat_in      = stat_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_z_in     = out_z_ff;
      if (cmd_pop) begin
         unique case (cmd.pos) inside
            POS_HEADER: begin
               xor_in   = cmd.data;
               match_in = 1'b0;
            end
            4'd1, 4'd2: xor_in = xor_ff ^ cmd.data;
            4'd3: begin
               xor_in   = xor_ff ^ cmd.data;
               spd_x_in = {cmd.data, spd_x_ff[7:0]};
            end
            4'd4: begin
               xor_in   = xor_ff ^ cmd.data;
               spd_x_in = {spd_x_ff[15:8], cmd.data};
            end
            4'd5: begin
               xor_in   = xor_ff ^ cmd.data;
               spd_y_in = {cmd.data, spd_y_ff[7:0]};
            end
            4'd6: begin
               xor_in   = xor_ff ^ cmd.data;
               spd_y_in = {spd_y_ff[15:8], cmd.data};
            end
            4'd7: begin
               xor_in   = xor_ff ^ cmd.data;
               spd_z_in = {cmd.data, spd_z_ff[7:0]};
            end
            POS_LAST_SPEED: begin
               xor_in   = xor_ff ^ cmd.data;
               spd_z_in = {spd_z_ff[15:8], cmd.data};
            end
            POS_CHECK: match_in = (cmd.data == xor_ff);
            POS_TAIL: begin
               out_valid_in = 1'b1;
               if (cmd.data != tail_byte) begin
                  stat_in = STAT_BAD_TAIL;
               end else if (!match_ff) begin
                  stat_in = STAT_BAD_SUM;
               end else begin
                  stat_in = STAT_OK;
               end
               if (cmd.data == tail_byte && match_ff) begin
                  out_x_in = spd_x_ff;
                  out_y_in = spd_y_ff;
                  out_z_in = spd_z_ff;
               end else begin
                  out_x_in = '0;
                  out_y_in = '0;
                  out_z_in = '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      spd_x_ff <= spd_x_in;
      spd_y_ff <= spd_y_in;
      spd_z_ff <= spd_z_in;
      stat_ff  <= stat_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_z_ff <= out_z_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_ff       <= '0;
         match_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         xor_ff       <= xor_in;
         match_ff     <= match_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign frame_status  = stat_ff;
   assign target_x_mm_s = out_x_ff;
   assign target_y_mm_s = out_y_ff;
   assign target_z_mm_s = out_z_ff;

endmodule
